// File: hw/rtl/bi0s_pkg.sv
// shared constants, types and state encoding of the bessel i0 series core
package bi0s_pkg;

	localparam int MAX_TERMS = 200;
	localparam int K_W       = $clog2(MAX_TERMS);
	localparam int D_W       = 2 * K_W;
	localparam logic [K_W-1:0] K_LAST = K_W'(MAX_TERMS - 1);

	localparam int X_W      = 24;
	localparam int SQ_W     = 2 * X_W;
	localparam int T_SHIFT  = 10;
	localparam int T_W      = 37;
	localparam int TERM_W   = 64;
	localparam int HALF_W   = TERM_W / 2;
	localparam int HP_W     = HALF_W + T_W;
	localparam int PROD_W   = TERM_W + T_W;
	localparam int FRAC     = 24;
	localparam int DVD_W    = PROD_W - FRAC;
	localparam int CHUNK    = 7;
	localparam int NCELL    = DVD_W / CHUNK;
	localparam int USED_W   = 8;

	localparam logic [TERM_W-1:0] ONE_Q24 = TERM_W'(1) << FRAC;

	typedef struct packed {
		logic [D_W-1:0]   rem;
		logic [DVD_W-1:0] dvd;
		logic [DVD_W-1:0] quo;
		logic [D_W-1:0]   dvs;
	} div_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_LAUNCH,
		ST_DIVW,
		ST_FIN
	} state_t;

endpackage

// File: hw/rtl/bi0s_if.sv
// valid/ready channel interfaces for argument and result words
interface bi0s_in_if;
	logic                        valid;
	logic                        ready;
	logic signed [bi0s_pkg::X_W-1:0] x_value;
	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

interface bi0s_out_if;
	logic                             valid;
	logic                             ready;
	logic [bi0s_pkg::TERM_W-1:0]      i0_result;
	logic                             overflow;
	logic [bi0s_pkg::USED_W-1:0]      terms_used;
	modport source (output valid, output i0_result, output overflow, output terms_used,
		input ready);
	modport sink (input valid, input i0_result, input overflow, input terms_used,
		output ready);
endinterface

// File: hw/rtl/bessel_i0_series_core.sv
// top level: modified bessel i0 by power series, fixed point
//
// x_in carries one signed q8.16 argument per word; i0_out returns one word
// with i0(x) as unsigned q40.24, an overflow flag and the count of terms.
// each series term forms the 64 x 37 product as two 32 x 37 half products
// (ST_MUL0, ST_MUL1), aligns and launches it (ST_LAUNCH), and passes it
// through the chain of 11 divider cells (7 quotient bits per cell)
// that divides by k*k. the result of an argument that stops after n terms
// is then loaded into the output register;
// n is 1 for zero and grows with |x|, at most 199.
// one argument is worked at a time; x_in is ready whenever the core is idle,
// even while a finished result still waits in the output register.
// if the receiver stalls, the next result waits in the core until the
// output register frees up, and x_in stays low meanwhile.
// reset (arst_n low) clears the state machine, the divider chain valid bits
// and the output valid; no word in flight survives it.
module bessel_i0_series_core (
	input  logic              clk,
	input  logic              arst_n,
	bi0s_in_if.sink           x_in,
	bi0s_out_if.source        i0_out
);
	bi0s_pkg::state_t state_q, state_nx;

	// per-argument working registers
	logic [bi0s_pkg::T_W-1:0]    t_q;
	logic [bi0s_pkg::TERM_W-1:0] term_q;
	logic [bi0s_pkg::TERM_W-1:0] sum_q;
	logic [bi0s_pkg::K_W-1:0]    k_q;
	logic [bi0s_pkg::D_W-1:0]    d_q;
	logic                        ovf_q;
	logic [bi0s_pkg::HP_W-1:0]   prod_lo_q;
	logic [bi0s_pkg::HP_W-1:0]   prod_hi_q;

	// output register
	logic                        out_valid_q;
	logic [bi0s_pkg::TERM_W-1:0] out_result_q;
	logic                        out_ovf_q;
	logic [bi0s_pkg::USED_W-1:0] out_used_q;

	// control
	logic in_ready;
	logic in_fire;
	logic launch;
	logic load_out;
	logic out_free;

	// argument magnitude and t = x*x/4 in q.24
	logic [bi0s_pkg::X_W-1:0]  mag;
	logic [bi0s_pkg::SQ_W-1:0] sq;
	logic [bi0s_pkg::T_W-1:0]  t_nx;

	// product alignment and divider chain
	logic [bi0s_pkg::PROD_W-1:0] prod;
	bi0s_pkg::div_word_t         chain_in;
	bi0s_pkg::div_word_t         chain_out;
	logic                        chain_out_valid;

	// accumulate step
	logic [bi0s_pkg::TERM_W-1:0] nterm;
	logic [bi0s_pkg::TERM_W:0]   sum_ext;
	logic                        q_big;
	logic                        step_ovf;
	logic                        step_stop;
	logic [bi0s_pkg::K_W-1:0]    k_nx;

	assign mag  = x_in.x_value[bi0s_pkg::X_W-1] ? (~x_in.x_value + 1'b1) : x_in.x_value;
	assign sq   = {{bi0s_pkg::X_W{1'b0}}, mag} * {{bi0s_pkg::X_W{1'b0}}, mag};
	assign t_nx = sq[bi0s_pkg::T_SHIFT +: bi0s_pkg::T_W];

	// recombine the two half products and drop the 24 fraction bits
	assign prod = {prod_hi_q, {bi0s_pkg::HALF_W{1'b0}}}
		+ {{(bi0s_pkg::PROD_W-bi0s_pkg::HP_W){1'b0}}, prod_lo_q};

	always_comb begin
		chain_in.rem = '0;
		chain_in.dvd = prod[bi0s_pkg::PROD_W-1:bi0s_pkg::FRAC];
		chain_in.quo = '0;
		chain_in.dvs = d_q;
	end

	bi0s_div_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (launch),
		.in_word   (chain_in),
		.out_valid (chain_out_valid),
		.out_word  (chain_out)
	);

	// quotient must fit 64 bits, then the running sum must not carry out
	assign nterm     = chain_out.quo[bi0s_pkg::TERM_W-1:0];
	assign q_big     = |chain_out.quo[bi0s_pkg::DVD_W-1:bi0s_pkg::TERM_W];
	assign sum_ext   = {1'b0, sum_q} + {1'b0, nterm};
	assign step_ovf  = q_big || sum_ext[bi0s_pkg::TERM_W];
	assign step_stop = step_ovf || (nterm == '0) || (k_q == bi0s_pkg::K_LAST);
	assign k_nx      = k_q + 1'b1;

	assign out_free = !out_valid_q || i0_out.ready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bi0s_pkg::ST_IDLE: begin
				if (x_in.valid) begin
					state_nx = bi0s_pkg::ST_MUL0;
				end
			end
			bi0s_pkg::ST_MUL0:   state_nx = bi0s_pkg::ST_MUL1;
			bi0s_pkg::ST_MUL1:   state_nx = bi0s_pkg::ST_LAUNCH;
			bi0s_pkg::ST_LAUNCH: state_nx = bi0s_pkg::ST_DIVW;
			bi0s_pkg::ST_DIVW: begin
				if (chain_out_valid) begin
					state_nx = step_stop ? bi0s_pkg::ST_FIN : bi0s_pkg::ST_MUL0;
				end
			end
			bi0s_pkg::ST_FIN: begin
				if (out_free) begin
					state_nx = bi0s_pkg::ST_IDLE;
				end
			end
			default: state_nx = bi0s_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		launch   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			bi0s_pkg::ST_IDLE:   in_ready = 1'b1;
			bi0s_pkg::ST_LAUNCH: launch   = 1'b1;
			bi0s_pkg::ST_FIN:    load_out = out_free;
			default: ;
		endcase
	end

	assign in_fire = x_in.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bi0s_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (i0_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			t_q    <= t_nx;
			term_q <= bi0s_pkg::ONE_Q24;
			sum_q  <= bi0s_pkg::ONE_Q24;
			k_q    <= bi0s_pkg::K_W'(1);
			d_q    <= bi0s_pkg::D_W'(1);
			ovf_q  <= 1'b0;
		end
		if (state_q == bi0s_pkg::ST_MUL0) begin
			prod_lo_q <= {{bi0s_pkg::T_W{1'b0}}, term_q[bi0s_pkg::HALF_W-1:0]}
				* {{bi0s_pkg::HALF_W{1'b0}}, t_q};
		end
		if (state_q == bi0s_pkg::ST_MUL1) begin
			prod_hi_q <= {{bi0s_pkg::T_W{1'b0}}, term_q[bi0s_pkg::TERM_W-1:bi0s_pkg::HALF_W]}
				* {{bi0s_pkg::HALF_W{1'b0}}, t_q};
		end
		if (state_q == bi0s_pkg::ST_DIVW && chain_out_valid) begin
			if (step_stop) begin
				sum_q <= step_ovf ? '1 : sum_ext[bi0s_pkg::TERM_W-1:0];
				ovf_q <= step_ovf;
			end else begin
				term_q <= nterm;
				sum_q  <= sum_ext[bi0s_pkg::TERM_W-1:0];
				k_q    <= k_nx;
				d_q    <= {{bi0s_pkg::K_W{1'b0}}, k_nx} * {{bi0s_pkg::K_W{1'b0}}, k_nx};
			end
		end
		if (load_out) begin
			out_result_q <= sum_q;
			out_ovf_q    <= ovf_q;
			out_used_q   <= bi0s_pkg::USED_W'(k_q);
		end
	end

	assign x_in.ready        = in_ready;
	assign i0_out.valid      = out_valid_q;
	assign i0_out.i0_result  = out_result_q;
	assign i0_out.overflow   = out_ovf_q;
	assign i0_out.terms_used = out_used_q;
endmodule

// File: hw/rtl/bi0s_div_cell.sv
// one divider cell: several restoring quotient bits, registered toward the next cell
module bi0s_div_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  bi0s_pkg::div_word_t   in_word,
	output logic                  out_valid,
	output bi0s_pkg::div_word_t   out_word
);
	logic [bi0s_pkg::D_W:0]     cur;
	logic [bi0s_pkg::D_W-1:0]   r;
	logic [bi0s_pkg::DVD_W-1:0] dv;
	logic [bi0s_pkg::DVD_W-1:0] qo;
	logic                       qb;
	bi0s_pkg::div_word_t        nxt;
	logic                       valid_q;
	bi0s_pkg::div_word_t        word_q;

	always_comb begin
		r  = in_word.rem;
		dv = in_word.dvd;
		qo = in_word.quo;
		cur = '0;
		qb = 1'b0;
		for (int i = 0; i < bi0s_pkg::CHUNK; i++) begin
			cur = {r, dv[bi0s_pkg::DVD_W-1]};
			dv  = {dv[bi0s_pkg::DVD_W-2:0], 1'b0};
			qb  = (cur >= {1'b0, in_word.dvs});
			if (qb) begin
				cur = cur - {1'b0, in_word.dvs};
			end
			qo = {qo[bi0s_pkg::DVD_W-2:0], qb};
			r  = cur[bi0s_pkg::D_W-1:0];
		end
		nxt.rem = r;
		nxt.dvd = dv;
		nxt.quo = qo;
		nxt.dvs = in_word.dvs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
endmodule

// File: hw/rtl/bi0s_div_chain.sv
// row of divider cells, remainder and quotient pass one cell per cycle
module bi0s_div_chain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  bi0s_pkg::div_word_t   in_word,
	output logic                  out_valid,
	output bi0s_pkg::div_word_t   out_word
);
	logic                v [bi0s_pkg::NCELL+1];
	bi0s_pkg::div_word_t w [bi0s_pkg::NCELL+1];

	assign v[0] = in_valid;
	assign w[0] = in_word;

	for (genvar g = 0; g < bi0s_pkg::NCELL; g++) begin : g_cell
		bi0s_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[g]),
			.in_word   (w[g]),
			.out_valid (v[g+1]),
			.out_word  (w[g+1])
		);
	end

	assign out_valid = v[bi0s_pkg::NCELL];
	assign out_word  = w[bi0s_pkg::NCELL];
endmodule

// File: hw/rtl/bi0s_checker.sv
// port-level checks on the bessel i0 series core and their binding
module bi0s_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [bi0s_pkg::TERM_W-1:0]       i0_result,
	input logic                              overflow,
	input logic [bi0s_pkg::USED_W-1:0]       terms_used
);
	// result valid holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// saturated result is all ones
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> (&i0_result))
		else $error("overflow without saturated result");

	// series never falls below its leading 1.0
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow |-> (i0_result >= bi0s_pkg::ONE_Q24))
		else $error("result below one");

	// term count within the series limit
	a_terms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (terms_used != '0)
			&& (terms_used <= bi0s_pkg::USED_W'(bi0s_pkg::MAX_TERMS - 1)))
		else $error("terms used out of range");
endmodule

bind bessel_i0_series_core bi0s_checker u_bi0s_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (i0_out.valid),
	.out_ready  (i0_out.ready),
	.i0_result  (i0_out.i0_result),
	.overflow   (i0_out.overflow),
	.terms_used (i0_out.terms_used)
);

// File: test/bi0s_tb_pkg.sv
// predictor types and the series computation used by the checker
`timescale 1ns / 1ps
package bi0s_tb_pkg;

	typedef struct {
		logic [63:0] value;
		logic        ovf;
		logic [7:0]  terms;
	} i0_word_t;

	// power series for i0 of a signed q8.16 argument, q40.24 result
	function automatic i0_word_t series_i0(logic signed [23:0] x);
		logic [23:0]  mag;
		logic [36:0]  t;
		logic [100:0] prod;
		logic [76:0]  quo;
		logic [64:0]  acc;
		logic [63:0]  term;
		logic [63:0]  sum;
		i0_word_t     r;
		int           k;
		mag = x[23] ? (~x + 24'd1) : x;
		t = 37'((48'(mag) * 48'(mag)) >> 10);
		term = 64'd1 << 24;
		sum = term;
		r.ovf = 1'b0;
		r.terms = 8'd0;
		for (k = 1; k < bi0s_pkg::MAX_TERMS; k++) begin
			r.terms = 8'(k);
			prod = 101'(term) * 101'(t);
			quo = 77'(prod >> 24) / 77'(k * k);
			if (quo[76:64] != 0) begin
				r.ovf = 1'b1;
				break;
			end
			term = quo[63:0];
			acc = 65'(sum) + 65'(term);
			if (acc[64]) begin
				r.ovf = 1'b1;
				break;
			end
			sum = acc[63:0];
			if (term == 0)
				break;
		end
		r.value = r.ovf ? '1 : sum;
		return r;
	endfunction

endpackage

// File: test/bi0s_checker.sv
// checker: watches both channels, predicts each result word and compares
`timescale 1ns / 1ps
module bi0s_tb_checker (
	input  logic     clk,
	input  logic     arst_n,
	bi0s_in_if       x_in,
	bi0s_out_if      i0_out,
	output int       errors,
	output int       pending
);
	bi0s_tb_pkg::i0_word_t awaited_i0[$];

	always @(posedge clk) begin
		bi0s_tb_pkg::i0_word_t w;
		if (arst_n) begin
			if (x_in.valid && x_in.ready)
				awaited_i0.push_back(bi0s_tb_pkg::series_i0(x_in.x_value));
			if (i0_out.valid && i0_out.ready) begin
				if (awaited_i0.size() == 0) begin
					errors <= errors + 1;
					$display("%0t: unexpected word i0=%h", $time, i0_out.i0_result);
				end else begin
					w = awaited_i0.pop_front();
					if (w.value !== i0_out.i0_result || w.ovf !== i0_out.overflow
						|| w.terms !== i0_out.terms_used) begin
						errors <= errors + 1;
						$display("%0t: expected i0=%h ovf=%b terms=%0d",
							$time, w.value, w.ovf, w.terms);
						$display("%0t: actual   i0=%h ovf=%b terms=%0d",
							$time, i0_out.i0_result, i0_out.overflow,
							i0_out.terms_used);
					end
				end
			end
		end
		pending <= awaited_i0.size();
	end

	initial begin
		errors = 0;
		pending = 0;
	end
endmodule

// File: test/testbench.sv
// testbench top: stimulus, clock, reset and verdict for the bessel i0 core
`timescale 1ns / 1ps
module testbench;
	localparam int N_RANDOM   = 1800;
	// worst case is a series of up to 199 terms plus stall time
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   quiet_cycles = 0;
	bit   calm = 1'b0;   // stretch with no idling on either side

	bi0s_in_if  x_in ();
	bi0s_out_if i0_out ();

	bessel_i0_series_core dut (.clk(clk), .arst_n(arst_n), .x_in(x_in), .i0_out(i0_out));

	bi0s_tb_checker chk (.clk(clk), .arst_n(arst_n), .x_in(x_in), .i0_out(i0_out),
		.errors(errors), .pending(pending));

	always #5 clk = ~clk;

	initial begin
		x_in.valid = 1'b0;
		x_in.x_value = '0;
		i0_out.ready = 1'b0;
	end

	// receiver stalls with a probability of about 13 percent, except during the calm stretch
	always @(posedge clk)
		i0_out.ready <= calm || ($urandom_range(99) >= 13);

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((x_in.valid && x_in.ready) || (i0_out.valid && i0_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one argument word, holding it until accepted; gaps only between words
	task automatic send_x(logic [23:0] v);
		while (!calm && $urandom_range(99) < 13) begin
			x_in.valid <= 1'b0;
			@(posedge clk);
		end
		x_in.valid <= 1'b1;
		x_in.x_value <= v;
		@(posedge clk);
		while (!x_in.ready)
			@(posedge clk);
	endtask

	// random argument: mostly small magnitudes that converge, sometimes any code
	function automatic logic [23:0] pick_x();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return 24'($urandom_range(32'h3FFFF)) ^ ($urandom_range(1) ? 24'hFFFFFF : 24'h0);
		else if (sel < 6)
			return 24'($urandom_range(32'h3FF));
		else
			return 24'($urandom);
	endfunction

	initial begin
		logic [23:0] directed[$];
		int i;
		directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
			24'h010000, 24'hFF0000, 24'h020000, 24'h080000, 24'hF80000,
			24'h100000, 24'h200000, 24'h2C0000, 24'h2E0000, 24'h300000,
			24'h400000, 24'hC00000, 24'h555555, 24'hAAAAAA, 24'h000400,
			24'h0000FF};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[j])
			send_x(directed[j]);
		for (i = 0; i < N_RANDOM; i++) begin
			// a calm stretch with no idling on either side
			calm <= (i >= 600 && i < 800);
			send_x(pick_x());
		end
		x_in.valid <= 1'b0;
		calm <= 1'b0;
		// let the checker count the last accepted word first
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
